// ----- sv/assert_macros.svh -----
// assertion macros used by the sorted priority queue sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SPQ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("spq assertion failed");

// consequent checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`endif

// ----- sv/spq_pkg.sv -----
// types and codes for the sorted priority queue
package spq_pkg;

   typedef enum logic [1:0] {
      MODE_ENQ  = 2'd0,
      MODE_DEQ  = 2'd1,
      MODE_PEEK = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_CMP,
      S_PLACE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [31:0]        data;
      logic signed [15:0] prio;
   } entry_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        data;
      logic signed [15:0] prio;
   } req_word_type;

   typedef struct packed {
      logic [31:0]        data;
      logic signed [15:0] prio;
      status_type         status;
   } rsp_word_type;

endpackage

// ----- sv/spq_if.sv -----
// request and response channel interfaces of the sorted priority queue
interface spq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [31:0]        data_in;
   logic signed [15:0] priority_in;

   modport source (output valid, output mode, output data_in, output priority_in,
                   input ready);
   modport sink (input valid, input mode, input data_in, input priority_in,
                 output ready);
endinterface

interface spq_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        data_out;
   logic signed [15:0] priority_out;
   logic [1:0]         status;

   modport source (output valid, output data_out, output priority_out, output status,
                   input ready);
   modport sink (input valid, input data_out, input priority_out, input status,
                 output ready);
endinterface

// ----- sv/spq_mem.sv -----
// entry store: one write port, one read port with registered read data
module spq_mem
   import spq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type store_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/spq_seq.sv -----
// sequencer: queue indices, insertion walk and the shared priority compare
`include "assert_macros.svh"

module spq_seq
   import spq_pkg::*;
#(
   parameter int CAPACITY = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  req_word_type                req_word,
   input  logic                        out_free,
   output logic                        rsp_load,
   output rsp_word_type                rsp_word,
   output logic                        mem_we,
   output logic [$clog2(CAPACITY)-1:0] mem_waddr,
   output entry_type                   mem_wdata,
   output logic                        mem_re,
   output logic [$clog2(CAPACITY)-1:0] mem_raddr,
   input  entry_type                   mem_rdata
);

   localparam int IDX_W = $clog2(CAPACITY);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(CAPACITY - 1)) ? '0 : IDX_W'(i + 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(CAPACITY - 1) : IDX_W'(i - 1'b1);
   endfunction

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic               empty_ff, empty_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   req_word_type       cmd_ff, cmd_in;
   rsp_word_type       res_ff, res_in;
   logic               full;
   entry_type          new_entry;

   assign full      = !empty_ff && (next_idx(tail_ff) == head_ff);
   assign new_entry = '{data: cmd_ff.data, prio: cmd_ff.prio};
   assign rsp_word  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = next_idx(idx_ff);
      mem_wdata = new_entry;
      mem_re    = 1'b0;
      mem_raddr = idx_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_word;
               res_in   = '{data: '0, prio: '0, status: STAT_OK};
               state_in = S_RESP;
               case (mode_type'(req_word.mode))
                  MODE_ENQ: begin
                     if (full) begin
                        res_in.status = STAT_FULL;
                     end else if (empty_ff) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = '{data: req_word.data, prio: req_word.prio};
                        head_in   = '0;
                        tail_in   = '0;
                        empty_in  = 1'b0;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = tail_ff;
                        idx_in    = tail_ff;
                        tail_in   = next_idx(tail_ff);
                        state_in  = S_CMP;
                     end
                  end
                  MODE_DEQ, MODE_PEEK: begin
                     if (empty_ff) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        state_in  = S_HEAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HEAD: begin
            res_in.data = mem_rdata.data;
            res_in.prio = mem_rdata.prio;
            if (mode_type'(cmd_ff.mode) == MODE_DEQ) begin
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else begin
                  head_in = next_idx(head_ff);
               end
            end
            state_in = S_RESP;
         end
         S_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = next_idx(idx_ff);
            if ($signed(mem_rdata.prio) >= $signed(cmd_ff.prio)) begin
               mem_wdata = new_entry;
               state_in  = S_RESP;
            end else begin
               // shift toward the tail and keep walking to the head
               mem_wdata = mem_rdata;
               if (idx_ff == head_ff) begin
                  state_in = S_PLACE;
               end else begin
                  idx_in    = prev_idx(idx_ff);
                  mem_re    = 1'b1;
                  mem_raddr = prev_idx(idx_ff);
               end
            end
         end
         S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = new_entry;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `SPQ_ASSERT(a_empty_idx_zero, clock, reset, empty_ff |-> (head_ff == '0 && tail_ff == '0))
   `SPQ_ASSERT(a_walk_nonempty, clock, reset, (state_ff == S_CMP || state_ff == S_PLACE) |-> !empty_ff)
   `SPQ_ASSERT_NEXT(a_peek_keeps, clock, reset, state_ff == S_HEAD && mode_type'(cmd_ff.mode) == MODE_PEEK, $stable(head_ff) && $stable(tail_ff) && $stable(empty_ff))

endmodule

// ----- sv/sorted_priority_queue.sv -----
// sorted priority queue top level: sequencer, entry store and response register
// enqueue into an empty or full queue and the unused mode go straight from idle to the response state
// dequeue and peek of a nonempty queue read the head first; enqueue into a busy queue walks one entry a cycle
// one word in flight, next word can be accepted in the cycle after the response loads;
// a held response keeps the sequencer waiting
// synchronous reset empties the queue; store contents are not cleared
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 8
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(CAPACITY);

   req_word_type     req_word;
   rsp_word_type     seq_rsp;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             rsp_load;
   logic             req_ready;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_rdata;

   assign req_word = '{mode: req_if.mode, data: req_if.data_in, prio: req_if.priority_in};
   assign req_if.ready = req_ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   spq_seq #(
      .CAPACITY(CAPACITY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_word  (seq_rsp),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   spq_mem #(
      .DEPTH(CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = seq_rsp;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.data_out     = rsp_word_ff.data;
   assign rsp_if.priority_out = rsp_word_ff.prio;
   assign rsp_if.status       = rsp_word_ff.status;

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the sorted priority queue
module tb_top
   import spq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH    = 8;
   localparam int STALL_MAX      = 12;
   localparam int LONG_HOLD      = 80;
   localparam int RANDOM_WORDS   = 1550;
   localparam int BURST_WORDS    = 40;
   localparam int IDLE_LIMIT     = 4000;
   localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 8;

   class priority_shadow;
      entry_type    held[$];
      rsp_word_type pending_rsp[$];
      int           depth;
      int           errors;

      function new(int depth_value);
         depth  = depth_value;
         errors = 0;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         entry_type    e;
         int           slot;
         r = '{data: '0, prio: '0, status: STAT_OK};
         case (mode_type'(w.mode))
            MODE_ENQ: begin
               if (held.size() == depth) begin
                  r.status = STAT_FULL;
               end else begin
                  e.data = w.data;
                  e.prio = w.prio;
                  slot   = held.size();
                  // new entry goes behind every entry of equal or higher priority
                  while (slot > 0 && held[slot-1].prio < w.prio)
                     slot--;
                  held.insert(slot, e);
               end
            end
            MODE_DEQ, MODE_PEEK: begin
               if (held.size() == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.data = held[0].data;
                  r.prio = held[0].prio;
                  if (mode_type'(w.mode) == MODE_DEQ)
                     void'(held.pop_front());
               end
            end
            default: ;
         endcase
         pending_rsp.push_back(r);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (pending_rsp.size() == 0) begin
            $display("%t unexpected word expected none actual %h %h %0d",
                     $realtime, got.data, got.prio, got.status);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.data !== want.data) begin
            $display("%t data_out expected %h actual %h", $realtime, want.data, got.data);
            errors++;
         end
         if (got.prio !== want.prio) begin
            $display("%t priority_out expected %0d actual %0d",
                     $realtime, want.prio, got.prio);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%t status expected %0d actual %0d", $realtime, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue #(
      .CAPACITY (QUEUE_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   priority_shadow shadow = new(QUEUE_DEPTH);

   bit sender_gaps;
   bit receiver_stalls;
   bit hold_off_pending;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic offer_word(input mode_type m, input logic [31:0] d,
                             input logic signed [15:0] p);
      int gap;
      gap = sender_gaps ? $urandom_range(0, STALL_MAX) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= m;
      req_if.data_in     <= d;
      req_if.priority_in <= p;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      shadow.note_request('{mode: m, data: d, prio: p});
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (shadow.pending_rsp.size() != 0);
   endtask

   function automatic logic signed [15:0] draw_priority();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         return 16'($signed($urandom_range(0, 4)) - 2);
      if (pick < 7) begin
         case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return -16'sd1;
            default: return 16'sd0;
         endcase
      end
      return 16'($urandom);
   endfunction

   function automatic mode_type draw_mode(int enq_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 2)
         return MODE_NOP;
      if ($urandom_range(1, 100) <= enq_pct)
         return MODE_ENQ;
      return ($urandom_range(0, 2) == 0) ? MODE_PEEK : MODE_DEQ;
   endfunction

   // response side
   initial begin
      int hold;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = receiver_stalls ? $urandom_range(0, STALL_MAX) : 0;
         if (hold_off_pending) begin
            hold             = LONG_HOLD;
            hold_off_pending = 1'b0;
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         shadow.check_response(rsp_word_type'({rsp_if.data_out, rsp_if.priority_out,
                                               rsp_if.status}));
         @(negedge clock);
      end
   end

   // watchdog on cycles without any accepted word
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   initial begin
      int sent;
      int burst;
      int enq_pct;
      mode_type m;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.mode        = MODE_ENQ;
      req_if.data_in     = '0;
      req_if.priority_in = '0;
      sender_gaps        = 1'b0;
      receiver_stalls    = 1'b0;
      hold_off_pending   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty queue, extremes, ties, full queue, unused mode
      offer_word(MODE_PEEK, 32'h0, 16'sd0);
      offer_word(MODE_DEQ, 32'h0, 16'sd0);
      offer_word(MODE_ENQ, 32'h0000_0000, 16'sd0);
      offer_word(MODE_PEEK, 32'h0, 16'sd0);
      offer_word(MODE_DEQ, 32'h0, 16'sd0);
      offer_word(MODE_DEQ, 32'h0, 16'sd0);
      offer_word(MODE_ENQ, 32'hffff_ffff, 16'sh8000);
      offer_word(MODE_ENQ, 32'h1111_0001, 16'sh7fff);
      offer_word(MODE_ENQ, 32'h2222_0002, 16'sd5);
      offer_word(MODE_ENQ, 32'h3333_0003, 16'sd5);
      offer_word(MODE_ENQ, 32'h4444_0004, -16'sd1);
      offer_word(MODE_ENQ, 32'h5555_0005, 16'sh7fff);
      offer_word(MODE_ENQ, 32'h6666_0006, 16'sd0);
      offer_word(MODE_ENQ, 32'h7777_0007, 16'sd5);
      offer_word(MODE_ENQ, 32'h8888_0008, 16'sh7fff);
      offer_word(MODE_NOP, 32'hffff_ffff, 16'shffff);
      offer_word(MODE_PEEK, 32'h0, 16'sd0);
      for (int i = 0; i < QUEUE_DEPTH + 1; i++)
         offer_word(MODE_DEQ, 32'h0, 16'sd0);

      sent  = 0;
      burst = 0;
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 50;
            default: enq_pct = 15;
         endcase
         sender_gaps     = 1'($urandom_range(0, 1));
         receiver_stalls = 1'($urandom_range(0, 1));
         if (burst == 8) begin
            // back-to-back offers while the response side holds off
            hold_off_pending = 1'b1;
            sender_gaps      = 1'b0;
         end
         if (burst == 16)
            wait_for_drain();
         for (int i = 0; i < BURST_WORDS; i++) begin
            m = draw_mode(enq_pct);
            offer_word(m, $urandom, draw_priority());
            if (m != MODE_NOP)
               sent++;
         end
         burst++;
      end

      req_if.valid <= 1'b0;
      while (shadow.pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shadow.errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_mem.sv
sv/spq_seq.sv
sv/sorted_priority_queue.sv
tb/sv/tb_top.sv
